[rtl/core/oeef_pkg.sv]
// Package for the object-id outline edge filter: widths, reset values,
// command and register codes, and the window type shared by the modules.
// No dependencies.
package oeef_pkg;

  localparam int unsigned KEY_BITS       = 16;
  localparam int unsigned TAG_W          = KEY_BITS + 1;
  localparam int unsigned MAX_LINE_WIDTH = 2048;
  localparam int unsigned COL_W          = $clog2(MAX_LINE_WIDTH);
  localparam int unsigned DIM_W          = 12;
  localparam int unsigned MARGIN_W       = 4;
  localparam int unsigned CHAN_W         = 8;
  localparam int unsigned RGB_W          = 3 * CHAN_W;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned CFG_DATA_W     = 12;

  localparam logic [DIM_W-1:0]    LINE_WIDTH_RST   = DIM_W'(1920);
  localparam logic [DIM_W-1:0]    FRAME_HEIGHT_RST = DIM_W'(1080);
  localparam logic [MARGIN_W-1:0] MARGIN_ROWS_RST  = MARGIN_W'(3);
  localparam logic [DIM_W-1:0]    MIN_DIM          = DIM_W'(2);
  localparam logic [DIM_W-1:0]    MAX_WIDTH_VAL    = DIM_W'(MAX_LINE_WIDTH);
  localparam logic [MARGIN_W-1:0] MIN_MARGIN       = MARGIN_W'(1);

  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_FLUSH = 1'b1
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LINE_WIDTH   = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_MARGIN_ROWS  = 2'd2
  } cfg_idx_e;

  // Object tag: valid bit above the key bits.
  typedef logic [TAG_W-1:0] tag_t;
  typedef logic [RGB_W-1:0] rgb_t;
  typedef logic [COL_W-1:0] col_t;

  // Neighborhood of one centre pixel.
  typedef struct packed {
    tag_t cen;
    tag_t left;
    tag_t right;
    tag_t up;
    tag_t below;
  } win_t;

endpackage

[rtl/core/oeef_pix_if.sv]
// Stream interfaces for the outline filter: pixel items in, result items out.
// Depends on oeef_pkg.
interface oeef_pix_in_if;
  logic                          valid;
  logic                          ready;
  logic                          cmd;
  logic                          obj_valid;
  logic [oeef_pkg::KEY_BITS-1:0] obj_key;
  logic [oeef_pkg::CHAN_W-1:0]   red_in;
  logic [oeef_pkg::CHAN_W-1:0]   green_in;
  logic [oeef_pkg::CHAN_W-1:0]   blue_in;

  modport source (output valid, cmd, obj_valid, obj_key, red_in, green_in, blue_in,
                  input ready);
  modport sink (input valid, cmd, obj_valid, obj_key, red_in, green_in, blue_in,
                output ready);
endinterface

interface oeef_pix_out_if;
  logic                        valid;
  logic                        ready;
  logic [oeef_pkg::CHAN_W-1:0] red_out;
  logic [oeef_pkg::CHAN_W-1:0] green_out;
  logic [oeef_pkg::CHAN_W-1:0] blue_out;
  logic                        is_outline;
  logic                        frame_last;

  modport source (output valid, red_out, green_out, blue_out, is_outline, frame_last,
                  input ready);
  modport sink (input valid, red_out, green_out, blue_out, is_outline, frame_last,
                output ready);
endinterface

[rtl/core/oeef_outline_dec.sv]
// Outline decision for one centre pixel from its four-neighbor window.
// Depends on oeef_pkg.
module oeef_outline_dec (
  input  oeef_pkg::win_t win_i,
  input  logic           in_area_i,
  output logic           outline_o
);

  logic no_obj;
  logic differs;

  always_comb begin
    // In the area, no object in the centre or to the right marks an edge.
    no_obj  = !win_i.cen[oeef_pkg::KEY_BITS] || !win_i.right[oeef_pkg::KEY_BITS];
    differs = (win_i.cen != win_i.left) || (win_i.cen != win_i.right) ||
              (win_i.cen != win_i.up) || (win_i.cen != win_i.below);
    outline_o = in_area_i && (no_obj || differs);
  end

endmodule

[rtl/core/object_id_outline_edge_filter_core.sv]
// Object-id outline edge filter, top level.
// Depends on oeef_pkg, oeef_pix_if.sv and oeef_outline_dec.
//
// Usage: pixels of a frame enter on pix_i in raster order, each with its color
// and the key of the object it shows. The block keeps the row above and the
// centre row in line stores, so the result for a pixel of row r leaves while
// row r+1 streams in, one result per pixel item from the second row on. The
// first row of a frame yields no results. After the last pixel of a frame, one
// flush item per column drains the final row; a flush with no row pending is
// dropped without a result. A pixel sent while a row is pending drains it as
// well and starts the next frame.
// Results are blackened on outline pixels (is_outline set); frame_last marks
// the last pixel of the frame.
// An accepted item passes the input stage, then the output register, before
// its result shows on pix_o. Throughput: one item per cycle while pix_o.ready
// holds. Each line store has one write port; the centre store has two read
// ports, the others one. A write that coincides with the next item's read is
// forwarded. Stalls: a stalled result holds in the output register while one
// more item is taken into the input stage; beyond that, pix_i.ready drops.
// Reset: counters, the left neighbor and the registers return to their
// defaults (1920 x 1080, margin 3). The line stores are not cleared; the
// first row of the first frame fills them before they are read.
// Configuration writes must go in only while the block is idle; not enforced.
module object_id_outline_edge_filter_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [oeef_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [oeef_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  oeef_pix_in_if.sink                         pix_i,
  oeef_pix_out_if.source                      pix_o
);

  localparam int unsigned DIM_W = oeef_pkg::DIM_W;
  localparam int unsigned COL_W = oeef_pkg::COL_W;

  // Configuration registers.
  logic [DIM_W-1:0]              cfg_w_q;
  logic [DIM_W-1:0]              cfg_h_q;
  logic [oeef_pkg::MARGIN_W-1:0] cfg_m_q;

  // Raster position and the centre key of the previous item (left neighbor).
  oeef_pkg::col_t   col_q, col_d;
  logic [DIM_W-1:0] row_q, row_d;
  oeef_pkg::tag_t   prev_q;

  // Line stores.
  oeef_pkg::tag_t upper_mem  [oeef_pkg::MAX_LINE_WIDTH];
  oeef_pkg::tag_t center_mem [oeef_pkg::MAX_LINE_WIDTH];
  oeef_pkg::rgb_t color_mem  [oeef_pkg::MAX_LINE_WIDTH];

  // Input stage.
  logic           s1_valid_q;
  oeef_pkg::col_t s1_c_q;
  oeef_pkg::tag_t s1_below_q;
  oeef_pkg::rgb_t s1_rgb_q;
  logic           s1_emit_q;
  logic           s1_area_q;
  logic           s1_last_q;

  oeef_pkg::tag_t rd_cen_q, rd_right_q, rd_up_q;
  oeef_pkg::rgb_t rd_rgb_q;
  logic           fwd_cen_q, fwd_right_q, fwd_up_q, fwd_rgb_q;
  oeef_pkg::tag_t fwd_below_q, fwd_upv_q;
  oeef_pkg::rgb_t fwd_rgbv_q;

  // Output register.
  logic           out_valid_q;
  oeef_pkg::rgb_t out_rgb_q;
  logic           out_outline_q;
  logic           out_last_q;

  // Effective register values.
  logic [DIM_W-1:0]              w_eff, h_eff;
  logic [oeef_pkg::MARGIN_W-1:0] m_eff;
  oeef_pkg::col_t                wm1;

  logic             is_flush, draining, ignored, in_fire, s1_load, s1_adv, in_ready;
  oeef_pkg::col_t   c, c_nxt;
  logic [DIM_W-1:0] r;
  logic [DIM_W:0]   r_plus_m;
  logic             emit, in_area, is_last;
  oeef_pkg::tag_t   below;
  oeef_pkg::rgb_t   rgb_in;

  oeef_pkg::win_t win;
  oeef_pkg::rgb_t cen_rgb;
  logic           outline;
  logic           wr_en;

  always_comb begin
    if (cfg_w_q < oeef_pkg::MIN_DIM) begin
      w_eff = oeef_pkg::MIN_DIM;
    end else if (cfg_w_q > oeef_pkg::MAX_WIDTH_VAL) begin
      w_eff = oeef_pkg::MAX_WIDTH_VAL;
    end else begin
      w_eff = cfg_w_q;
    end
    h_eff = (cfg_h_q < oeef_pkg::MIN_DIM) ? oeef_pkg::MIN_DIM : cfg_h_q;
    m_eff = (cfg_m_q == '0) ? oeef_pkg::MIN_MARGIN : cfg_m_q;
    wm1   = COL_W'(w_eff - DIM_W'(1));
  end

  // Handshake and position of the arriving item.
  always_comb begin
    s1_adv   = !out_valid_q || pix_o.ready;
    in_ready = !s1_valid_q || s1_adv;
    in_fire  = pix_i.valid && in_ready;
    is_flush = (pix_i.cmd == oeef_pkg::CMD_FLUSH);
    draining = (row_q >= h_eff);
    ignored  = is_flush && !draining;
    s1_load  = in_fire && !ignored;

    c        = (col_q < wm1) ? col_q : wm1;
    c_nxt    = c + COL_W'(1);
    emit     = (row_q != '0);
    r        = row_q - DIM_W'(1);
    r_plus_m = {1'b0, r} + (DIM_W + 1)'(m_eff);
    in_area  = (r >= DIM_W'(m_eff)) && (r_plus_m < {1'b0, h_eff}) && (c < wm1);
    is_last  = (r == h_eff - DIM_W'(1)) && (c == wm1);

    below  = is_flush ? '0 : {pix_i.obj_valid, pix_i.obj_key};
    rgb_in = is_flush ? '0 : {pix_i.red_in, pix_i.green_in, pix_i.blue_in};

    col_d = col_q;
    row_d = row_q;
    if (s1_load) begin
      if (c >= wm1) begin
        col_d = '0;
        if (draining) begin
          row_d = is_flush ? '0 : DIM_W'(1);
        end else begin
          row_d = row_q + DIM_W'(1);
        end
      end else begin
        col_d = c_nxt;
      end
    end
  end

  assign pix_i.ready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q <= oeef_pkg::LINE_WIDTH_RST;
      cfg_h_q <= oeef_pkg::FRAME_HEIGHT_RST;
      cfg_m_q <= oeef_pkg::MARGIN_ROWS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        oeef_pkg::CFG_LINE_WIDTH:   cfg_w_q <= cfg_wdata_i;
        oeef_pkg::CFG_FRAME_HEIGHT: cfg_h_q <= cfg_wdata_i;
        oeef_pkg::CFG_MARGIN_ROWS:  cfg_m_q <= cfg_wdata_i[oeef_pkg::MARGIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Window of the item in the input stage. A line-store write made at the
  // edge that loaded this item is not seen by its registered read, so it is
  // taken from the forwarding registers instead.
  always_comb begin
    win.cen   = fwd_cen_q ? fwd_below_q : rd_cen_q;
    win.right = fwd_right_q ? fwd_below_q : rd_right_q;
    win.up    = fwd_up_q ? fwd_upv_q : rd_up_q;
    win.left  = prev_q;
    win.below = s1_below_q;
    cen_rgb   = fwd_rgb_q ? fwd_rgbv_q : rd_rgb_q;
    wr_en     = s1_valid_q && s1_adv;
  end

  oeef_outline_dec u_dec (
    .win_i     (win),
    .in_area_i (s1_area_q),
    .outline_o (outline)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      prev_q      <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (wr_en) begin
        prev_q <= win.cen;
      end
      s1_valid_q <= s1_load || (s1_valid_q && !s1_adv);
      if (s1_adv) begin
        out_valid_q <= s1_valid_q && s1_emit_q;
      end
    end
  end

  // Input stage payload, registered reads and forwarding capture.
  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_c_q      <= c;
      s1_below_q  <= below;
      s1_rgb_q    <= rgb_in;
      s1_emit_q   <= emit;
      s1_area_q   <= in_area;
      s1_last_q   <= is_last;
      rd_cen_q    <= center_mem[c];
      rd_right_q  <= center_mem[c_nxt];
      rd_up_q     <= upper_mem[c];
      rd_rgb_q    <= color_mem[c];
      fwd_cen_q   <= wr_en && (s1_c_q == c);
      fwd_right_q <= wr_en && (s1_c_q == c_nxt);
      fwd_up_q    <= wr_en && (s1_c_q == c);
      fwd_rgb_q   <= wr_en && (s1_c_q == c);
      fwd_below_q <= s1_below_q;
      fwd_upv_q   <= win.cen;
      fwd_rgbv_q  <= s1_rgb_q;
    end
  end

  // The centre row moves up and the arriving row takes its place.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      upper_mem[s1_c_q]  <= win.cen;
      center_mem[s1_c_q] <= s1_below_q;
      color_mem[s1_c_q]  <= s1_rgb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      out_rgb_q     <= outline ? '0 : cen_rgb;
      out_outline_q <= outline;
      out_last_q    <= s1_last_q;
    end
  end

  assign pix_o.valid      = out_valid_q;
  assign pix_o.red_out    = out_rgb_q[2*oeef_pkg::CHAN_W +: oeef_pkg::CHAN_W];
  assign pix_o.green_out  = out_rgb_q[oeef_pkg::CHAN_W +: oeef_pkg::CHAN_W];
  assign pix_o.blue_out   = out_rgb_q[0 +: oeef_pkg::CHAN_W];
  assign pix_o.is_outline = out_outline_q;
  assign pix_o.frame_last = out_last_q;

endmodule
